// ----- rtl/core/bpa_pkg.sv -----
// shared constants, codes and types of the bitmap page allocator
`timescale 1ns / 1ps

package bpa_pkg;

   localparam int MAX_PAGES  = 65536;
   localparam int PAGE_BYTES = 4096;
   localparam int WORD_BITS  = 64;

   localparam int MAP_WORDS  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W    = $clog2(MAP_WORDS);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int PAGE_W     = WADDR_W + BIT_W;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

   localparam int OP_W   = 3;
   localparam int ADDR_W = 64;
   localparam int CNT_W  = 17;
   localparam int LPG_W  = ADDR_W - PAGE_SHIFT + 1;

   localparam logic [OP_W-1:0] OP_ALLOC     = 3'd0;
   localparam logic [OP_W-1:0] OP_FREE      = 3'd1;
   localparam logic [OP_W-1:0] OP_MARK_FREE = 3'd2;
   localparam logic [OP_W-1:0] OP_MARK_USED = 3'd3;
   localparam logic [OP_W-1:0] OP_FINISH    = 3'd4;

   typedef enum logic [1:0] {
      WM_FIND = 2'd0,
      WM_SET  = 2'd1,
      WM_CLR  = 2'd2
   } wmode_type;

   typedef struct packed {
      logic                 hit;
      logic [BIT_W-1:0]     hit_bit;
      logic [WORD_BITS-1:0] new_word;
      logic [BIT_W:0]       delta;
   } weval_type;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] page_addr;
      logic [CNT_W-1:0]  free_count;
   } res_type;

endpackage

// ----- rtl/core/bitmap_page_allocator.sv -----
// Bitmap page-frame allocator, one used bit per page in a 1024 x 64 map memory.
// After reset the map is filled with ones, during which no transaction is
// accepted; csr writes are taken at any time. One transaction is worked on at a
// time, each word visit reading the map memory once. Allocate visits map words
// from the rover, wrapping once; mark free and mark used visit each map word the
// clipped range spans. Free page and finish init visit a single word, and
// rejected requests visit none. A finished result sits in an output register,
// so the next transaction is accepted while it waits to be taken.
`timescale 1ns / 1ps

module bitmap_page_allocator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [bpa_pkg::OP_W-1:0]   req_op,
   input  logic [bpa_pkg::ADDR_W-1:0] req_start_addr,
   input  logic [bpa_pkg::ADDR_W-1:0] req_end_addr,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_ok,
   output logic [bpa_pkg::ADDR_W-1:0] rsp_page_addr,
   output logic [bpa_pkg::CNT_W-1:0]  rsp_free_count,
   output logic [bpa_pkg::CNT_W-1:0]  rsp_used_count,
   input  logic                       csr_wr_en,
   input  logic [bpa_pkg::CNT_W-1:0]  csr_wr_data
);
   import bpa_pkg::*;

   logic [CNT_W-1:0]  page_limit_ff;
   logic [CNT_W-1:0]  eff_total;
   logic              res_ready, res_valid;
   res_type           res;

   logic              rsp_valid_ff;
   logic              rsp_ok_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [CNT_W-1:0]  rsp_free_ff, rsp_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_limit_ff <= CNT_W'(MAX_PAGES);
      end else if (csr_wr_en) begin
         page_limit_ff <= csr_wr_data;
      end
   end

   assign eff_total = (page_limit_ff > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                          : page_limit_ff;

   bpa_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_start_addr (req_start_addr),
      .req_end_addr   (req_end_addr),
      .total          (eff_total),
      .res_ready      (res_ready),
      .res_valid      (res_valid),
      .res            (res)
   );

   assign res_ready = !rsp_valid_ff || !rsp_stall;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_ok_ff   <= res.ok;
         rsp_addr_ff <= res.page_addr;
         rsp_free_ff <= res.free_count;
         rsp_used_ff <= (eff_total >= res.free_count) ? (eff_total - res.free_count) : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_page_addr  = rsp_addr_ff;
   assign rsp_free_count = rsp_free_ff;
   assign rsp_used_count = rsp_used_ff;

endmodule

// ----- rtl/core/bpa_word_eval.sv -----
// per-word bit search, set/clear and changed-bit count
`timescale 1ns / 1ps

module bpa_word_eval (
   input  logic [bpa_pkg::WORD_BITS-1:0] data,
   input  logic [bpa_pkg::WORD_BITS-1:0] mask,
   input  bpa_pkg::wmode_type            mode,
   output bpa_pkg::weval_type            ev
);
   import bpa_pkg::*;

   logic [WORD_BITS-1:0] changed;
   logic [BIT_W-1:0]     first_bit;
   logic [BIT_W:0]       count;

   assign changed = (mode == WM_CLR) ? (data & mask) : (~data & mask);

   always_comb begin
      first_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (changed[i]) begin
            first_bit = BIT_W'(i);
         end
      end
   end

   always_comb begin
      count = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         count = count + (BIT_W + 1)'(changed[i]);
      end
   end

   always_comb begin
      ev.hit     = |changed;
      ev.hit_bit = first_bit;
      ev.delta   = count;
      case (mode)
         WM_FIND: ev.new_word = data | (WORD_BITS'(1) << first_bit);
         WM_SET:  ev.new_word = data | mask;
         WM_CLR:  ev.new_word = data & ~mask;
         default: ev.new_word = data;
      endcase
   end

endmodule

// ----- rtl/core/bpa_engine.sv -----
// page map memory, sequencer for all operations and allocator state
`timescale 1ns / 1ps

module bpa_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [bpa_pkg::OP_W-1:0]    req_op,
   input  logic [bpa_pkg::ADDR_W-1:0]  req_start_addr,
   input  logic [bpa_pkg::ADDR_W-1:0]  req_end_addr,
   input  logic [bpa_pkg::CNT_W-1:0]   total,
   input  logic                        res_ready,
   output logic                        res_valid,
   output bpa_pkg::res_type            res
);
   import bpa_pkg::*;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_SETUP = 7'b0000100,
      S_READ  = 7'b0001000,
      S_EVAL  = 7'b0010000,
      S_ACC   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 mem_we;
   logic [WADDR_W-1:0]   mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;

   logic [OP_W-1:0]    op_ff;
   logic [ADDR_W-1:0]  sa_ff, ea_ff;
   logic [WADDR_W-1:0] cur_w_ff, lo_w_ff, end_w_ff, clr_ff;
   logic [BIT_W-1:0]   lo_b_ff, end_b_ff;
   logic               wrapped_ff;
   wmode_type          wmode_ff;
   logic [BIT_W:0]     delta_ff;
   logic [PAGE_W-1:0]  rover_ff;
   logic [CNT_W-1:0]   free_count_ff;
   logic               ready_ff;
   logic               ok_ff;
   logic [ADDR_W-1:0]  addr_ff;

   logic [WORD_BITS-1:0] ones, mask_hi, mask_lo, mask;
   weval_type            ev;

   logic [PAGE_W-1:0]  start_pg, tot_m1, hit_pg, req_pg, last_pg;
   logic [CNT_W-1:0]   hit_next, hic;
   logic [LPG_W-1:0]   sa_floor, sa_ceil, ea_floor, ea_ceil, lo_pg, hi_pg;
   logic               range_empty, free_ok;

   // memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= map_mem[cur_w_ff];
   end

   assign mem_we    = (state_ff == S_CLEAR) || ((state_ff == S_EVAL) && ev.hit);
   assign mem_waddr = (state_ff == S_CLEAR) ? clr_ff : cur_w_ff;
   assign mem_wdata = (state_ff == S_CLEAR) ? ones : ev.new_word;

   // word masks
   assign ones    = '1;
   assign mask_hi = (cur_w_ff == end_w_ff) ?
                    (ones >> (BIT_W'(WORD_BITS - 1) - end_b_ff)) : ones;
   assign mask_lo = (cur_w_ff != lo_w_ff) ? ones :
                    wrapped_ff ? ~(ones << lo_b_ff) : (ones << lo_b_ff);
   assign mask    = mask_hi & mask_lo;

   bpa_word_eval u_word_eval (
      .data (rd_data_ff),
      .mask (mask),
      .mode (wmode_ff),
      .ev   (ev)
   );

   // request decode
   assign start_pg = (CNT_W'(rover_ff) < total) ? rover_ff : '0;
   assign tot_m1   = PAGE_W'(total - CNT_W'(1));
   assign sa_floor = {1'b0, sa_ff[ADDR_W-1:PAGE_SHIFT]};
   assign ea_floor = {1'b0, ea_ff[ADDR_W-1:PAGE_SHIFT]};
   assign sa_ceil  = sa_floor + LPG_W'(|sa_ff[PAGE_SHIFT-1:0]);
   assign ea_ceil  = ea_floor + LPG_W'(|ea_ff[PAGE_SHIFT-1:0]);
   assign lo_pg    = (op_ff == OP_MARK_FREE) ? sa_ceil : sa_floor;
   assign hi_pg    = (op_ff == OP_MARK_FREE) ? ea_floor : ea_ceil;
   assign hic      = (hi_pg > LPG_W'(total)) ? total : CNT_W'(hi_pg);
   assign range_empty = lo_pg >= LPG_W'(hic);
   assign last_pg  = PAGE_W'(hic - CNT_W'(1));
   assign req_pg   = sa_ff[PAGE_SHIFT +: PAGE_W];
   assign free_ok  = ready_ff && (sa_ff[PAGE_SHIFT-1:0] == '0) &&
                     (sa_floor < LPG_W'(total));

   assign hit_pg   = {cur_w_ff, ev.hit_bit};
   assign hit_next = CNT_W'(hit_pg) + CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == WADDR_W'(MAP_WORDS - 1)) state_in = S_IDLE;
         S_IDLE:  if (req_valid) state_in = S_SETUP;
         S_SETUP: begin
            case (op_ff)
               OP_ALLOC: begin
                  if (ready_ff && (free_count_ff != '0) && (total != '0)) begin
                     state_in = S_READ;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               OP_FREE: state_in = free_ok ? S_READ : S_DONE;
               OP_MARK_FREE, OP_MARK_USED: begin
                  state_in = ((ea_ff > sa_ff) && !range_empty) ? S_READ : S_DONE;
               end
               OP_FINISH: state_in = (total != '0) ? S_READ : S_DONE;
               default: state_in = S_DONE;
            endcase
         end
         S_READ: state_in = S_EVAL;
         S_EVAL: begin
            if (wmode_ff != WM_FIND) begin
               state_in = S_ACC;
            end else if (ev.hit || (wrapped_ff && (cur_w_ff == lo_w_ff))) begin
               state_in = S_DONE;
            end else begin
               state_in = S_READ;
            end
         end
         S_ACC:  state_in = (cur_w_ff == end_w_ff) ? S_DONE : S_READ;
         S_DONE: if (res_ready) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rover_ff      <= '0;
         free_count_ff <= '0;
         ready_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_CLEAR: clr_ff <= clr_ff + WADDR_W'(1);
            S_SETUP: begin
               if (op_ff == OP_FINISH) begin
                  ready_ff <= 1'b1;
                  rover_ff <= (total > CNT_W'(1)) ? PAGE_W'(1) : '0;
               end
            end
            S_EVAL: begin
               if (wmode_ff == WM_FIND) begin
                  if (ev.hit) begin
                     free_count_ff <= free_count_ff - CNT_W'(1);
                     rover_ff      <= (hit_next >= total) ? '0 : PAGE_W'(hit_next);
                  end
               end else if ((op_ff == OP_FREE) && ev.hit && (hit_pg < rover_ff)) begin
                  rover_ff <= hit_pg;
               end
            end
            S_ACC: begin
               if (wmode_ff == WM_CLR) begin
                  free_count_ff <= free_count_ff + CNT_W'(delta_ff);
               end else begin
                  free_count_ff <= free_count_ff - CNT_W'(delta_ff);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            op_ff <= req_op;
            sa_ff <= req_start_addr;
            ea_ff <= req_end_addr;
         end
         S_SETUP: begin
            wrapped_ff <= 1'b0;
            ok_ff      <= 1'b0;
            addr_ff    <= '0;
            case (op_ff)
               OP_ALLOC: begin
                  addr_ff  <= '1;
                  wmode_ff <= WM_FIND;
                  cur_w_ff <= start_pg[PAGE_W-1:BIT_W];
                  lo_w_ff  <= start_pg[PAGE_W-1:BIT_W];
                  lo_b_ff  <= start_pg[BIT_W-1:0];
                  end_w_ff <= tot_m1[PAGE_W-1:BIT_W];
                  end_b_ff <= tot_m1[BIT_W-1:0];
               end
               OP_FREE: begin
                  wmode_ff <= WM_CLR;
                  cur_w_ff <= req_pg[PAGE_W-1:BIT_W];
                  lo_w_ff  <= req_pg[PAGE_W-1:BIT_W];
                  lo_b_ff  <= req_pg[BIT_W-1:0];
                  end_w_ff <= req_pg[PAGE_W-1:BIT_W];
                  end_b_ff <= req_pg[BIT_W-1:0];
               end
               OP_MARK_FREE, OP_MARK_USED: begin
                  ok_ff    <= ea_ff > sa_ff;
                  wmode_ff <= (op_ff == OP_MARK_FREE) ? WM_CLR : WM_SET;
                  cur_w_ff <= lo_pg[PAGE_W-1:BIT_W];
                  lo_w_ff  <= lo_pg[PAGE_W-1:BIT_W];
                  lo_b_ff  <= lo_pg[BIT_W-1:0];
                  end_w_ff <= last_pg[PAGE_W-1:BIT_W];
                  end_b_ff <= last_pg[BIT_W-1:0];
               end
               OP_FINISH: begin
                  ok_ff    <= 1'b1;
                  wmode_ff <= WM_SET;
                  cur_w_ff <= '0;
                  lo_w_ff  <= '0;
                  lo_b_ff  <= '0;
                  end_w_ff <= '0;
                  end_b_ff <= '0;
               end
               default: ;
            endcase
         end
         S_EVAL: begin
            delta_ff <= ev.delta;
            if (wmode_ff == WM_FIND) begin
               if (ev.hit) begin
                  ok_ff   <= 1'b1;
                  addr_ff <= ADDR_W'(hit_pg) << PAGE_SHIFT;
               end else if (cur_w_ff == end_w_ff) begin
                  cur_w_ff   <= '0;
                  wrapped_ff <= 1'b1;
               end else begin
                  cur_w_ff <= cur_w_ff + WADDR_W'(1);
               end
            end else if (op_ff == OP_FREE) begin
               ok_ff <= ev.hit;
            end
         end
         S_ACC: cur_w_ff <= cur_w_ff + WADDR_W'(1);
         default: ;
      endcase
   end

   assign req_stall      = state_ff != S_IDLE;
   assign res_valid      = state_ff == S_DONE;
   assign res.ok         = ok_ff;
   assign res.page_addr  = addr_ff;
   assign res.free_count = free_count_ff;

   a_accept_setup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_SETUP))
      else $error("accepted transaction did not enter setup");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= CNT_W'(MAX_PAGES))
      else $error("free page count above map size");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == S_EVAL) || (state_ff == S_CLEAR)))
      else $error("map write outside evaluate or clear");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready) |=> (state_ff == S_IDLE))
      else $error("result handed over but sequencer not idle");

endmodule

// ----- sim/bpa_checker.sv -----
// checker for the bitmap page allocator: tracks the page map, predicts and compares each result
`timescale 1ns / 1ps

module bpa_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [bpa_pkg::OP_W-1:0]   req_op,
   input  logic [bpa_pkg::ADDR_W-1:0] req_start_addr,
   input  logic [bpa_pkg::ADDR_W-1:0] req_end_addr,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic                       rsp_ok,
   input  logic [bpa_pkg::ADDR_W-1:0] rsp_page_addr,
   input  logic [bpa_pkg::CNT_W-1:0]  rsp_free_count,
   input  logic [bpa_pkg::CNT_W-1:0]  rsp_used_count,
   input  logic                       csr_wr_en,
   input  logic [bpa_pkg::CNT_W-1:0]  csr_wr_data,
   output int                         fail_count,
   output int                         pending
);
   import bpa_pkg::*;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] page_addr;
      logic [CNT_W-1:0]  free_count;
      logic [CNT_W-1:0]  used_count;
   } outcome_type;

   logic [WORD_BITS-1:0] page_map [MAP_WORDS];
   logic [CNT_W-1:0]     total_reg;
   int                   rover;
   int                   free_cnt;
   bit                   ready;
   outcome_type          awaited [$];
   int                   mismatches = 0;

   // bits of word w that fall inside pages [lo, hi)
   function automatic logic [WORD_BITS-1:0] span_mask(int w, int lo, int hi);
      int base;
      int lo_off;
      int hi_off;
      base   = w * WORD_BITS;
      lo_off = (lo > base) ? lo - base : 0;
      hi_off = (hi - base < WORD_BITS) ? hi - base : WORD_BITS;
      return ({WORD_BITS{1'b1}} << lo_off) & ~({WORD_BITS{1'b1}} << hi_off);
   endfunction

   function automatic void mark_pages(int lo, int hi, bit used);
      logic [WORD_BITS-1:0] flip;
      for (int w = lo / WORD_BITS; w <= (hi - 1) / WORD_BITS; w++) begin
         flip = span_mask(w, lo, hi) & (used ? ~page_map[w] : page_map[w]);
         page_map[w] ^= flip;
         free_cnt += used ? -$countones(flip) : $countones(flip);
      end
   endfunction

   function automatic int first_free(int lo, int hi);
      logic [WORD_BITS-1:0] open_bits;
      for (int w = lo / WORD_BITS; w <= (hi - 1) / WORD_BITS; w++) begin
         open_bits = ~page_map[w] & span_mask(w, lo, hi);
         for (int b = 0; b < WORD_BITS; b++)
            if (open_bits[b]) return w * WORD_BITS + b;
      end
      return -1;
   endfunction

   function automatic outcome_type serve_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] sa,
                                                 logic [ADDR_W-1:0] ea);
      outcome_type       r;
      int                tot;
      int                start;
      int                pg;
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      tot = (total_reg > MAX_PAGES) ? MAX_PAGES : int'(total_reg);
      r.ok = 1'b0;
      r.page_addr = '0;
      case (op)
         OP_ALLOC: begin
            r.page_addr = '1;
            if (ready && free_cnt != 0 && tot != 0) begin
               start = (rover < tot) ? rover : 0;
               pg = first_free(start, tot);
               if (pg < 0 && start > 0) pg = first_free(0, start);
               if (pg >= 0) begin
                  mark_pages(pg, pg + 1, 1'b1);
                  rover = (pg + 1 >= tot) ? 0 : pg + 1;
                  r.page_addr = 64'(pg) << PAGE_SHIFT;
                  r.ok = 1'b1;
               end
            end
         end
         OP_FREE: begin
            lo = sa >> PAGE_SHIFT;
            if (ready && sa[PAGE_SHIFT-1:0] == '0 && lo < tot) begin
               pg = int'(lo);
               if (page_map[pg / WORD_BITS][pg % WORD_BITS]) begin
                  mark_pages(pg, pg + 1, 1'b0);
                  if (pg < rover) rover = pg;
                  r.ok = 1'b1;
               end
            end
         end
         OP_MARK_FREE, OP_MARK_USED: begin
            if (ea > sa) begin
               r.ok = 1'b1;
               if (op == OP_MARK_FREE) begin
                  lo = (sa >> PAGE_SHIFT) + (sa[PAGE_SHIFT-1:0] != '0);
                  hi = ea >> PAGE_SHIFT;
               end else begin
                  lo = sa >> PAGE_SHIFT;
                  hi = (ea >> PAGE_SHIFT) + (ea[PAGE_SHIFT-1:0] != '0);
               end
               if (hi > tot) hi = tot;
               if (lo < hi) mark_pages(int'(lo), int'(hi), op == OP_MARK_USED);
            end
         end
         OP_FINISH: begin
            if (tot > 0) mark_pages(0, 1, 1'b1);
            rover = (tot > 1) ? 1 : 0;
            ready = 1'b1;
            r.ok = 1'b1;
         end
         default: begin
         end
      endcase
      r.free_count = free_cnt[CNT_W-1:0];
      r.used_count = (tot >= free_cnt) ? CNT_W'(tot - free_cnt) : '0;
      return r;
   endfunction

   function automatic void check_field(string name, logic [ADDR_W-1:0] want,
                                       logic [ADDR_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      outcome_type want;
      if (reset) begin
         foreach (page_map[w]) page_map[w] = '1;
         rover     = 0;
         free_cnt  = 0;
         ready     = 1'b0;
         total_reg = CNT_W'(MAX_PAGES);
         awaited.delete();
      end else begin
         if (csr_wr_en) total_reg = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               $error("result with no transaction outstanding");
               mismatches++;
            end else begin
               want = awaited.pop_front();
               check_field("ok", ADDR_W'(want.ok), ADDR_W'(rsp_ok));
               check_field("page_addr", want.page_addr, rsp_page_addr);
               check_field("free_count", ADDR_W'(want.free_count), ADDR_W'(rsp_free_count));
               check_field("used_count", ADDR_W'(want.used_count), ADDR_W'(rsp_used_count));
            end
         end
         if (req_valid && !req_stall)
            awaited.push_back(serve_request(req_op, req_start_addr, req_end_addr));
      end
      fail_count <= mismatches;
      pending    <= awaited.size();
   end

endmodule

// ----- sim/tb_bitmap_page_allocator.sv -----
// testbench top for the bitmap page allocator: stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb_bitmap_page_allocator;
   import bpa_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
   localparam int CYCLE_LIMIT  = 40_000_000;
   localparam int DRAIN_CYCLES = 3200;
   localparam int PHASE_ITEMS  = 200;

   int phase_totals [9] = '{64, 1, 0, 200, 65535, 129, 4096, 65536, 2};

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [OP_W-1:0]   req_op;
   logic [ADDR_W-1:0] req_start_addr;
   logic [ADDR_W-1:0] req_end_addr;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_ok;
   logic [ADDR_W-1:0] rsp_page_addr;
   logic [CNT_W-1:0]  rsp_free_count;
   logic [CNT_W-1:0]  rsp_used_count;
   logic              csr_wr_en;
   logic [CNT_W-1:0]  csr_wr_data;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int stall_left  = 0;
   int sent_by_op [8];
   bit gaps_on     = 1'b1;
   bit stall_on    = 1'b1;

   bitmap_page_allocator u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_start_addr (req_start_addr),
      .req_end_addr   (req_end_addr),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_page_addr  (rsp_page_addr),
      .rsp_free_count (rsp_free_count),
      .rsp_used_count (rsp_used_count),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   bpa_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_start_addr (req_start_addr),
      .req_end_addr   (req_end_addr),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_page_addr  (rsp_page_addr),
      .rsp_free_count (rsp_free_count),
      .rsp_used_count (rsp_used_count),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side back-pressure: mostly short runs, now and then a long one
   always @(posedge clock) begin : rsp_pressure
      int r;
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         r = $urandom_range(0, 99);
         if (stall_on && r >= 96) stall_left = $urandom_range(15, 60);
         else if (stall_on && r >= 70) stall_left = $urandom_range(1, 3);
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] sa,
                            input logic [ADDR_W-1:0] ea);
      int r;
      int gap;
      r = $urandom_range(0, 99);
      gap = 0;
      if (gaps_on && r >= 92) gap = $urandom_range(12, 50);
      else if (gaps_on && r >= 65) gap = $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_start_addr <= sa;
      req_end_addr   <= ea;
      do @(posedge clock); while (req_stall);
      sent_by_op[op]++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin : stimulus
      int                t;
      int                k;
      int                j;
      int                pg;
      int                total_sent;
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] sa;
      logic [ADDR_W-1:0] ea;
      logic [ADDR_W-1:0] base;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = OP_ALLOC;
      req_start_addr = '0;
      req_end_addr   = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      foreach (sent_by_op[i]) sent_by_op[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // before finish init nothing can be allocated or freed
      send_item(OP_ALLOC, '0, '0);
      send_item(OP_FREE, 64'h1000, '0);
      for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
         send_item(c[OP_W-1:0], '1, '1);
      send_item(OP_MARK_FREE, 64'h5000, 64'h5000);
      send_item(OP_MARK_USED, 64'h9000, 64'h3000);
      send_item(OP_MARK_FREE, 64'h1001, 64'h5000);
      send_item(OP_MARK_FREE, 64'h0, 64'h30fff);
      send_item(OP_FINISH, '0, '0);
      send_item(OP_ALLOC, '0, '0);
      send_item(OP_ALLOC, '1, '1);
      // freeing below the rover pulls it back
      send_item(OP_FREE, 64'h1000, '0);
      send_item(OP_FREE, 64'h1000, '0);
      send_item(OP_FREE, 64'h2001, '0);
      send_item(OP_FREE, 64'hffff_ffff_ffff_f000, '0);
      send_item(OP_MARK_USED, 64'h2fff, 64'h3001);
      send_item(OP_MARK_FREE, 64'hffff_ffff_ffff_f001, '1);
      send_item(OP_MARK_USED, '0, '1);
      send_item(OP_ALLOC, '0, '0);
      send_item(OP_FREE, 64'h0, '0);
      send_item(OP_MARK_FREE, '0, '1);
      send_item(OP_FINISH, '0, '0);
      send_item(OP_FINISH, '0, '0);
      send_item(OP_ALLOC, '0, '0);

      for (int ph = 0; ph < $size(phase_totals); ph++) begin
         t = phase_totals[ph];
         settle();
         csr_wr_en   <= 1'b1;
         csr_wr_data <= t[CNT_W-1:0];
         @(posedge clock);
         csr_wr_en <= 1'b0;
         gaps_on = (ph % 3 != 1);
         stall_on <= (ph % 3 != 2);

         // usual boot: release the usable range, then finish init
         if ($urandom_range(0, 3) != 0) begin
            send_item(OP_MARK_FREE, 64'($urandom_range(0, PAGE_BYTES - 1)),
                      (64'(t) << PAGE_SHIFT) + 64'($urandom_range(0, 2 * PAGE_BYTES)));
            send_item(OP_FINISH, '0, '0);
         end

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            k  = $urandom_range(0, 99);
            j  = $urandom_range(0, 19);
            pg = $urandom_range(0, t + 1);
            sa = {$urandom, $urandom};
            ea = {$urandom, $urandom};
            base = (64'(pg) << PAGE_SHIFT) + 64'($urandom_range(0, PAGE_BYTES - 1));
            if (k < 34) begin
               op = OP_ALLOC;
            end else if (k < 58) begin
               op = OP_FREE;
               if (j < 14) sa = 64'(pg) << PAGE_SHIFT;
               else if (j < 18) sa = (64'(pg) << PAGE_SHIFT) | 64'($urandom_range(1, 4095));
            end else if (k < 90) begin
               op = (k < 74) ? OP_MARK_FREE : OP_MARK_USED;
               sa = base;
               if (j == 0) begin
                  ea = base >> $urandom_range(0, 2);
               end else if (j == 1) begin
                  ea = base + 64'($urandom_range(1, (t + 1) * PAGE_BYTES));
               end else if (j == 2) begin
                  sa = '1 - 64'($urandom_range(0, 3 * PAGE_BYTES));
                  ea = '1 - 64'($urandom_range(0, PAGE_BYTES));
               end else begin
                  ea = base + 64'($urandom_range(1, 64 * PAGE_BYTES));
               end
            end else if (k < 94) begin
               op = OP_FINISH;
            end else if (k < 97) begin
               op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            end else begin
               op = $urandom_range(0, 1) ? OP_MARK_FREE : OP_MARK_USED;
            end
            send_item(op, sa, ea);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      total_sent = 0;
      foreach (sent_by_op[i]) total_sent += sent_by_op[i];
      $display("covered %0d transactions over %0d page count settings, 0 to %0d pages",
               total_sent, $size(phase_totals) + 1, MAX_PAGES);
      $display("allocate %0d, free page %0d, mark range %0d, finish init %0d, spare codes %0d",
               sent_by_op[OP_ALLOC], sent_by_op[OP_FREE],
               sent_by_op[OP_MARK_FREE] + sent_by_op[OP_MARK_USED], sent_by_op[OP_FINISH],
               sent_by_op[5] + sent_by_op[6] + sent_by_op[7]);
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
